>>> hdl/qet_pkg.sv
// Shared types and constants for the quadratic ease tween core.
// No dependencies; imported by qet_div and quadratic_ease_tween_core.
package qet_pkg;

  localparam int POS_W      = 32;
  localparam int TIME_W     = 32;
  localparam int TICK_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int Q_W        = 18;
  localparam int W_W        = 17;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 19;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);
  localparam logic [Q_W-1:0] TWO_Q16 = Q_W'(131072);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_START_Z,
    REG_END_X,
    REG_END_Y,
    REG_END_Z,
    REG_DURATION,
    REG_EASE_MODE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_IN,
    MODE_OUT,
    MODE_IN_OUT,
    MODE_ZERO
  } ease_mode_t;

endpackage

>>> hdl/quadratic_ease_tween_core.sv
// Quadratic ease tween core: moves a 3D Q16.16 point from start to end over a duration.
// A moving tick runs through the serial divider, then through one shared multiplier for the
// weight and each axis. Start items and ignored ticks are handled in IDLE alone; ending and
// zero-mode ticks pass through CHECK and DONE.
// One item is in work at a time; the next transfer is taken once the result is registered.
// Synchronous active-low reset clears the settings, state, output valid, elapsed time and the running flag.
module quadratic_ease_tween_core
  import qet_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [TICK_W-1:0]            in_tick_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [POS_W-1:0]      out_pos_x,
  output logic signed [POS_W-1:0]      out_pos_y,
  output logic signed [POS_W-1:0]      out_pos_z,
  output logic                         out_finished
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_WMUL,
    ST_WFIN,
    ST_LMUL,
    ST_LADD,
    ST_DONE
  } state_t;

  state_t                   state_r;
  logic [POS_W-1:0]         start_x_r, start_y_r, start_z_r;
  logic [POS_W-1:0]         end_x_r, end_y_r, end_z_r;
  logic [TIME_W-1:0]        duration_r;
  ease_mode_t               ease_mode_r;
  logic [TIME_W-1:0]        elapsed_r;
  logic                     running_r;
  logic [1:0]               axis_r;
  logic [W_W-1:0]           w_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [POS_W-1:0]         res_x_r, res_y_r, res_z_r;
  logic                     res_fin_r;
  logic                     out_valid_r;
  logic [POS_W-1:0]         out_x_r, out_y_r, out_z_r;
  logic                     out_fin_r;

  logic                     div_start;
  logic                     div_done;
  logic [Q_W-1:0]           div_q;

  logic [TIME_W:0]          tick_sum;
  logic [TIME_W-1:0]        elapsed_sat;
  logic [Q_W-1:0]           a_q;
  logic [Q_W-1:0]           b_q;
  logic                     hi_half;
  logic [POS_W-1:0]         sel_s, sel_e;
  logic signed [POS_W:0]    delta;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] rnd_sh;
  logic [POS_W-1:0]         lerp_pos;
  logic [Q_W-1:0]           w_hi_sum;
  logic [W_W-1:0]           w_nxt;
  logic                     out_free;
  logic                     out_load;

  qet_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed_r),
    .divisor  (duration_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    tick_sum    = {1'b0, elapsed_r} + {{(TIME_W + 1 - TICK_W){1'b0}}, in_tick_time};
    elapsed_sat = tick_sum[TIME_W] ? '1 : tick_sum[TIME_W-1:0];

    a_q     = {1'b0, div_q[Q_W-1:1]};
    hi_half = (div_q >= ONE_Q16);
    b_q     = div_q - ONE_Q16;

    unique case (axis_r)
      2'd0: begin
        sel_s = start_x_r;
        sel_e = end_x_r;
      end
      2'd1: begin
        sel_s = start_y_r;
        sel_e = end_y_r;
      end
      default: begin
        sel_s = start_z_r;
        sel_e = end_z_r;
      end
    endcase
    delta = $signed({sel_e[POS_W-1], sel_e}) - $signed({sel_s[POS_W-1], sel_s});

    if (state_r == ST_LMUL) begin
      mul_a = {delta[POS_W], delta};
      mul_b = $signed({{(MUL_B_W - W_W){1'b0}}, w_r});
    end else begin
      unique case (ease_mode_r)
        MODE_IN: begin
          mul_a = $signed({{(MUL_A_W - Q_W){1'b0}}, a_q});
          mul_b = $signed({1'b0, a_q});
        end
        MODE_OUT: begin
          mul_a = $signed({{(MUL_A_W - Q_W){1'b0}}, a_q});
          mul_b = $signed({1'b0, TWO_Q16 - a_q});
        end
        default: begin
          if (hi_half) begin
            mul_a = $signed({{(MUL_A_W - Q_W){1'b0}}, b_q});
            mul_b = $signed({1'b0, TWO_Q16 - b_q});
          end else begin
            mul_a = $signed({{(MUL_A_W - Q_W){1'b0}}, div_q});
            mul_b = $signed({1'b0, div_q});
          end
        end
      endcase
    end
    prod = mul_a * mul_b;

    w_hi_sum = ONE_Q16 + prod_r[33:16];
    if (ease_mode_r == MODE_IN_OUT) begin
      w_nxt = hi_half ? w_hi_sum[Q_W-1:1] : prod_r[33:17];
    end else begin
      w_nxt = prod_r[32:16];
    end

    rnd      = prod_r + PROD_W'(32768);
    rnd_sh   = rnd >>> 16;
    lerp_pos = sel_s + rnd_sh[POS_W-1:0];

    div_start = (state_r == ST_CHECK) && !(duration_r == '0 || elapsed_r > duration_r)
                && (ease_mode_r != MODE_ZERO);
    out_free  = !out_valid_r || !out_stall;
    out_load  = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_x_r   <= '0;
      start_y_r   <= '0;
      start_z_r   <= '0;
      end_x_r     <= '0;
      end_y_r     <= '0;
      end_z_r     <= '0;
      duration_r  <= '0;
      ease_mode_r <= MODE_IN;
      elapsed_r   <= '0;
      running_r   <= 1'b0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_START_X:   start_x_r   <= cfg_wdata[POS_W-1:0];
          REG_START_Y:   start_y_r   <= cfg_wdata[POS_W-1:0];
          REG_START_Z:   start_z_r   <= cfg_wdata[POS_W-1:0];
          REG_END_X:     end_x_r     <= cfg_wdata[POS_W-1:0];
          REG_END_Y:     end_y_r     <= cfg_wdata[POS_W-1:0];
          REG_END_Z:     end_z_r     <= cfg_wdata[POS_W-1:0];
          REG_DURATION:  duration_r  <= cfg_wdata[TIME_W-1:0];
          REG_EASE_MODE: ease_mode_r <= ease_mode_t'(cfg_wdata[1:0]);
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_kind == KIND_START) begin
              elapsed_r <= '0;
              running_r <= 1'b1;
            end else if (running_r) begin
              elapsed_r <= elapsed_sat;
              state_r   <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (duration_r == '0 || elapsed_r > duration_r) begin
            res_x_r   <= end_x_r;
            res_y_r   <= end_y_r;
            res_z_r   <= end_z_r;
            res_fin_r <= 1'b1;
            running_r <= 1'b0;
            state_r   <= ST_DONE;
          end else if (ease_mode_r == MODE_ZERO) begin
            res_x_r   <= '0;
            res_y_r   <= '0;
            res_z_r   <= '0;
            res_fin_r <= 1'b0;
            state_r   <= ST_DONE;
          end else begin
            res_fin_r <= 1'b0;
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_WMUL;
          end
        end
        ST_WMUL: begin
          prod_r  <= prod;
          state_r <= ST_WFIN;
        end
        ST_WFIN: begin
          w_r     <= w_nxt;
          axis_r  <= '0;
          state_r <= ST_LMUL;
        end
        ST_LMUL: begin
          prod_r  <= prod;
          state_r <= ST_LADD;
        end
        ST_LADD: begin
          unique case (axis_r)
            2'd0:    res_x_r <= lerp_pos;
            2'd1:    res_y_r <= lerp_pos;
            default: res_z_r <= lerp_pos;
          endcase
          if (axis_r == 2'd2) begin
            state_r <= ST_DONE;
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= ST_LMUL;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_x_r     <= res_x_r;
            out_y_r     <= res_y_r;
            out_z_r     <= res_z_r;
            out_fin_r   <= res_fin_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_pos_x    = $signed(out_x_r);
  assign out_pos_y    = $signed(out_y_r);
  assign out_pos_z    = $signed(out_z_r);
  assign out_finished = out_fin_r;

endmodule

>>> hdl/qet_div.sv
// Restoring bit-serial divider giving floor(dividend * 2^17 / divisor), one bit per cycle.
// The dividend must not exceed the divisor. Depends on qet_pkg.
module qet_div
  import qet_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [Q_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(Q_W);

  logic [TIME_W:0]   rem_r;
  logic [Q_W-1:0]    quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [TIME_W:0]   trial;
  logic              ge;
  logic [TIME_W:0]   rem_nxt;

  always_comb begin
    trial   = (cnt_r == '0) ? rem_r : {rem_r[TIME_W-1:0], 1'b0};
    ge      = (trial >= {1'b0, divisor});
    rem_nxt = ge ? (trial - {1'b0, divisor}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= {1'b0, dividend};
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[Q_W-2:0], ge};
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for quadratic_ease_tween_core, with its own fixed-point tween predictor.
// Depends on qet_pkg and the core; drives directed, long-duration and random motions with idling.
module testbench
  import qet_pkg::*;
();

  localparam int SETTLE_CYCLES     = 40;
  localparam int CYCLE_LIMIT       = 2_000_000;
  localparam int WIDE_TICKS        = 24;
  localparam int MOTIONS_PER_PHASE = 16;
  localparam int MAX_GAP           = 20;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic             finished;
  } position_t;

  class tween_scoreboard;
    logic [CFG_DATA_W-1:0] settings [8];
    logic [TIME_W-1:0]     elapsed;
    bit                    running;
    position_t             pending_positions [$];
    int                    errors;

    function new();
      foreach (settings[i]) settings[i] = '0;
      elapsed = '0;
      running = 1'b0;
      errors  = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      settings[idx] = value;
    endfunction

    function logic [31:0] eased_weight();
      logic [63:0] span, a, a2, b;
      span = 64'(settings[REG_DURATION]);
      case (ease_mode_t'(settings[REG_EASE_MODE][1:0]))
        MODE_IN: begin
          a = (64'(elapsed) << 16) / span;
          return 32'((a * a) >> 16);
        end
        MODE_OUT: begin
          a = (64'(elapsed) << 16) / span;
          return 32'((a * (64'(TWO_Q16) - a)) >> 16);
        end
        default: begin
          a2 = (64'(elapsed) << 17) / span;
          if (a2 < 64'(ONE_Q16)) return 32'((a2 * a2) >> 17);
          b = a2 - 64'(ONE_Q16);
          return 32'((64'(ONE_Q16) + ((b * (64'(TWO_Q16) - b)) >> 16)) >> 1);
        end
      endcase
    endfunction

    // Round to nearest with ties toward plus infinity, which an arithmetic shift gives.
    function logic [POS_W-1:0] lerp_axis(logic [POS_W-1:0] from, logic [POS_W-1:0] to,
                                         logic [31:0] w);
      longint origin, delta, prod;
      origin = longint'(signed'(from));
      delta  = longint'(signed'(to)) - origin;
      prod   = delta * longint'({32'd0, w});
      return POS_W'(origin + ((prod + 64'sd32768) >>> 16));
    endfunction

    function void note_input(logic kind, logic [TICK_W-1:0] tick);
      logic [TIME_W:0] sum;
      logic [31:0]     w;
      position_t       result;
      if (kind == KIND_START) begin
        elapsed = '0;
        running = 1'b1;
        return;
      end
      if (!running) return;
      sum = 33'(elapsed) + 33'(tick);
      elapsed = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      if (settings[REG_DURATION] == '0 || elapsed > settings[REG_DURATION]) begin
        result = '{settings[REG_END_X], settings[REG_END_Y], settings[REG_END_Z], 1'b1};
        running = 1'b0;
      end else if (ease_mode_t'(settings[REG_EASE_MODE][1:0]) == MODE_ZERO) begin
        result = '0;
      end else begin
        w = eased_weight();
        result.x = lerp_axis(settings[REG_START_X], settings[REG_END_X], w);
        result.y = lerp_axis(settings[REG_START_Y], settings[REG_END_Y], w);
        result.z = lerp_axis(settings[REG_START_Z], settings[REG_END_Z], w);
        result.finished = 1'b0;
      end
      pending_positions.push_back(result);
    endfunction

    task report(string what);
      $display("[%0t] %s", $time, what);
      errors++;
    endtask

    task check_result(logic [POS_W-1:0] got_x, logic [POS_W-1:0] got_y,
                      logic [POS_W-1:0] got_z, logic got_finished);
      position_t want;
      if (pending_positions.size() == 0) begin
        report($sformatf("result with nothing pending: x=%h y=%h z=%h finished=%b",
                         got_x, got_y, got_z, got_finished));
        return;
      end
      want = pending_positions.pop_front();
      if (got_x !== want.x) report($sformatf("pos_x %h, expected %h", got_x, want.x));
      if (got_y !== want.y) report($sformatf("pos_y %h, expected %h", got_y, want.y));
      if (got_z !== want.z) report($sformatf("pos_z %h, expected %h", got_z, want.z));
      if (got_finished !== want.finished)
        report($sformatf("finished %b, expected %b", got_finished, want.finished));
    endtask
  endclass

  logic                    clk          = 1'b0;
  logic                    rst_n        = 1'b0;
  logic                    cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index    = REG_START_X;
  logic [CFG_DATA_W-1:0]   cfg_wdata    = '0;
  logic                    in_valid     = 1'b0;
  logic                    in_stall;
  logic                    in_kind      = KIND_START;
  logic [TICK_W-1:0]       in_tick_time = '0;
  logic                    out_valid;
  logic                    out_stall    = 1'b0;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic signed [POS_W-1:0] out_pos_z;
  logic                    out_finished;

  tween_scoreboard       tracker;
  logic [CFG_DATA_W-1:0] next_settings [8];
  int                    idle_pct    = 0;
  int                    stall_pct   = 0;
  int                    cycle_count = 0;

  quadratic_ease_tween_core dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(out_pos_x, out_pos_y, out_pos_z, out_finished);
  end

  task automatic send_item(input logic kind, input logic [TICK_W-1:0] tick);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_tick_time <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_input(kind, tick);
  endtask

  // The core is only reprogrammed once every result is back and any silent item has drained.
  task automatic load_settings();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = REG_START_X; i <= REG_EASE_MODE; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= next_settings[i];
      @(posedge clk);
      tracker.set_reg(cfg_reg_t'(i), next_settings[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_duration();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom;
      default: return $urandom_range(1 << 24, 2);
    endcase
  endfunction

  task automatic run_motion();
    int          steps;
    int          choice;
    logic [31:0] span;
    for (int i = REG_START_X; i <= REG_END_Z; i++) next_settings[i] = pick_position();
    next_settings[REG_DURATION]  = pick_duration();
    next_settings[REG_EASE_MODE] = $urandom;
    load_settings();
    if ($urandom_range(9) != 0) send_item(KIND_START, TICK_W'($urandom));
    steps = $urandom_range(20, 4);
    span  = next_settings[REG_DURATION] / steps * 2 + 1;
    if (span > 32'h000F_FFFF) span = 32'h000F_FFFF;
    repeat (steps) begin
      choice = $urandom_range(19);
      if (choice == 0) send_item(KIND_START, TICK_W'($urandom));
      else if (choice < 3) send_item(KIND_TICK, TICK_W'($urandom));
      else send_item(KIND_TICK, TICK_W'($urandom_range(span)));
    end
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Settings are still at reset, so the duration is zero.
    send_item(KIND_TICK, '0);
    send_item(KIND_START, '0);
    send_item(KIND_TICK, '1);
    send_item(KIND_TICK, '0);

    for (int m = MODE_IN; m <= MODE_ZERO; m++) begin
      next_settings[REG_START_X]   = 32'h8000_0000;
      next_settings[REG_START_Y]   = 32'h7FFF_FFFF;
      next_settings[REG_START_Z]   = 32'h0000_0000;
      next_settings[REG_END_X]     = 32'h7FFF_FFFF;
      next_settings[REG_END_Y]     = 32'h8000_0000;
      next_settings[REG_END_Z]     = 32'hFFFF_0000;
      next_settings[REG_DURATION]  = 32'd100;
      next_settings[REG_EASE_MODE] = 32'(m);
      load_settings();
      send_item(KIND_START, '1);
      send_item(KIND_TICK, 20'd50);
      if (m == MODE_ZERO) send_item(KIND_START, '0);
      else send_item(KIND_TICK, '0);
      send_item(KIND_TICK, 20'd50);
      send_item(KIND_TICK, 20'd51);
    end

    // With the longest duration, runs of the largest ticks give the widest dividends.
    for (int i = REG_START_X; i <= REG_END_Z; i++) next_settings[i] = pick_position();
    next_settings[REG_DURATION]  = 32'hFFFF_FFFF;
    next_settings[REG_EASE_MODE] = 32'(MODE_IN_OUT);
    load_settings();
    send_item(KIND_START, '0);
    repeat (WIDE_TICKS) send_item(KIND_TICK, '1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 70;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 70;
        end
        default: begin
          idle_pct  = 27;
          stall_pct = 27;
        end
      endcase
      repeat (MOTIONS_PER_PHASE) run_motion();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
